FILE: src/w2s_pkg.sv
// Shared constants, types and helpers for the world-to-screen projection unit.
// No dependencies; imported by every module of the block.
package w2s_pkg;

  // Fixed-point format of coordinates and coefficients
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int CFG_W     = 64;
  localparam int SCR_W     = 14;

  // Dot product widths
  localparam int PROD_W = 2 * COORD_W;
  localparam int SUM_W  = PROD_W - FRAC_BITS + 2;

  // Divider: dividend is |clip| scaled up by the fraction, divisor is w
  localparam int DIV_W = COORD_W + FRAC_BITS;
  localparam int DEN_W = COORD_W - 1;

  // Normalized coordinate clamp at +-2^39
  localparam int NDC_MAG_W = 40;
  localparam int NDC_W     = NDC_MAG_W + 1;
  localparam logic [NDC_MAG_W-1:0] NDC_LIM = NDC_MAG_W'(1) << (NDC_MAG_W - 1);

  // Viewport product and sum widths
  localparam int VP_PROD_W = NDC_W + SCR_W + 1;
  localparam int VP_SUM_W  = VP_PROD_W + 1;

  // Smallest w counted as visible: ceil(0.001 * 2^FRAC_BITS)
  localparam int THRESH = ((1 << FRAC_BITS) + 999) / 1000;

  // Scale for clip coordinates of hidden points
  localparam int HID_SCALE = 100000;
  localparam int HID_W     = COORD_W + 18;

  // Delay from accepted start to result strobe
  localparam int LATENCY = DIV_W + 6;

  localparam logic [SCR_W-1:0] WIDTH_RST  = SCR_W'(1920);
  localparam logic [SCR_W-1:0] HEIGHT_RST = SCR_W'(1080);

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ROW0_AB = 3'd0,
    REG_ROW0_CD = 3'd1,
    REG_ROW1_AB = 3'd2,
    REG_ROW1_CD = 3'd3,
    REG_ROW3_AB = 3'd4,
    REG_ROW3_CD = 3'd5,
    REG_WIDTH   = 3'd6,
    REG_HEIGHT  = 3'd7
  } cfg_reg_t;

  // Per-item sideband carried alongside the divider
  typedef struct packed {
    logic                      vis;
    logic                      neg_x;
    logic                      neg_y;
    logic signed [COORD_W-1:0] hid_x;
    logic signed [COORD_W-1:0] hid_y;
  } side_t;

  // Saturate a signed value to signed 32 bits
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat32 = COORD_W'(hi);
    end else if (v < lo) begin
      sat32 = COORD_W'(lo);
    end else begin
      sat32 = COORD_W'(v);
    end
  endfunction

endpackage

FILE: src/w2s_dot.sv
// One matrix row times (x, y, z, 1), two register stages, saturated result.
// Depends on w2s_pkg.
module w2s_dot import w2s_pkg::*; (
  input  logic                      clk,
  input  logic [CFG_W-1:0]          coef_ab,
  input  logic [CFG_W-1:0]          coef_cd,
  input  logic signed [COORD_W-1:0] x,
  input  logic signed [COORD_W-1:0] y,
  input  logic signed [COORD_W-1:0] z,
  output logic signed [COORD_W-1:0] clip_r
);

  logic signed [PROD_W-1:0]  p0_r, p1_r, p2_r;
  logic signed [COORD_W-1:0] c3_r;
  logic signed [SUM_W-1:0]   sum;

  // Stage 1: the three coefficient products
  always_ff @(posedge clk) begin
    p0_r <= $signed(coef_ab[COORD_W-1:0]) * x;
    p1_r <= $signed(coef_ab[CFG_W-1:COORD_W]) * y;
    p2_r <= $signed(coef_cd[COORD_W-1:0]) * z;
    c3_r <= $signed(coef_cd[CFG_W-1:COORD_W]);
  end

  // Floor-shift each product, add the translation
  assign sum = SUM_W'(p0_r >>> FRAC_BITS) + SUM_W'(p1_r >>> FRAC_BITS)
             + SUM_W'(p2_r >>> FRAC_BITS) + SUM_W'(c3_r);

  // Stage 2: saturated clip coordinate
  always_ff @(posedge clk) begin
    clip_r <= sat32(64'(sum));
  end

endmodule

FILE: src/w2s_div.sv
// Pipelined restoring divider for x and y by a shared w, one quotient bit per stage.
// Depends on w2s_pkg.
module w2s_div import w2s_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  side_t            in_side,
  input  logic [DIV_W-1:0] num_x,
  input  logic [DIV_W-1:0] num_y,
  input  logic [DEN_W-1:0] den,
  output logic             out_vld,
  output side_t            out_side,
  output logic [DIV_W-1:0] quo_x,
  output logic [DIV_W-1:0] quo_y
);

  logic             vld_r  [DIV_W];
  side_t            side_r [DIV_W];
  logic [DEN_W-1:0] den_r  [DIV_W];
  logic [DEN_W-1:0] rx_r   [DIV_W];
  logic [DEN_W-1:0] ry_r   [DIV_W];
  logic [DIV_W-1:0] nx_r   [DIV_W];
  logic [DIV_W-1:0] ny_r   [DIV_W];

  for (genvar s = 0; s < DIV_W; s++) begin : g_stage
    logic             vld_p;
    side_t            side_p;
    logic [DEN_W-1:0] den_p, rx_p, ry_p;
    logic [DIV_W-1:0] nx_p, ny_p;
    logic [DEN_W:0]   tx, ty;
    logic             gex, gey;

    if (s == 0) begin : g_first
      assign vld_p  = in_vld;
      assign side_p = in_side;
      assign den_p  = den;
      assign rx_p   = '0;
      assign ry_p   = '0;
      assign nx_p   = num_x;
      assign ny_p   = num_y;
    end else begin : g_next
      assign vld_p  = vld_r[s-1];
      assign side_p = side_r[s-1];
      assign den_p  = den_r[s-1];
      assign rx_p   = rx_r[s-1];
      assign ry_p   = ry_r[s-1];
      assign nx_p   = nx_r[s-1];
      assign ny_p   = ny_r[s-1];
    end

    // Bring down the next dividend bit and try the subtract
    assign tx  = {rx_p, nx_p[DIV_W-1]};
    assign ty  = {ry_p, ny_p[DIV_W-1]};
    assign gex = tx >= {1'b0, den_p};
    assign gey = ty >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_p;
      end
    end

    // Quotient bits shift in as dividend bits leave
    always_ff @(posedge clk) begin
      side_r[s] <= side_p;
      den_r[s]  <= den_p;
      rx_r[s]   <= gex ? DEN_W'(tx - {1'b0, den_p}) : DEN_W'(tx);
      ry_r[s]   <= gey ? DEN_W'(ty - {1'b0, den_p}) : DEN_W'(ty);
      nx_r[s]   <= {nx_p[DIV_W-2:0], gex};
      ny_r[s]   <= {ny_p[DIV_W-2:0], gey};
    end
  end

  assign out_vld  = vld_r[DIV_W-1];
  assign out_side = side_r[DIV_W-1];
  assign quo_x    = nx_r[DIV_W-1];
  assign quo_y    = ny_r[DIV_W-1];

endmodule

FILE: src/world_to_screen_projection_unit.sv
// Top level of the world-to-screen projection unit: config registers, pipeline, output.
// Depends on w2s_pkg, w2s_dot and w2s_div.
//
// Usage:
//   Input: drive in_world_x/y/z (signed Q16.16) with start high; a beat is
//   taken at every clock edge with start high. busy is always low, so a new
//   point may enter in every cycle.
//   Output: out_valid pulses for one cycle with out_screen_x/y and
//   out_visible. The result must be taken in that cycle; there is no stall.
//   Pipeline: 2 dot-product stages, one prepare stage, 48 divider stages
//   at one quotient bit each, 3 viewport stages. Throughput: one point per
//   cycle.
//   Config: cfg_we writes cfg_wdata to register cfg_index.
//   Write only while no point is in flight.
//   Reset (rst_n low, synchronous) empties the pipeline and loads a zero
//   matrix and a 1920x1080 viewport.
//   Points with w below 0.001 come out with out_visible low and the clip
//   coordinates scaled by 100000.
module world_to_screen_projection_unit import w2s_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_world_x,
  input  logic signed [COORD_W-1:0] in_world_y,
  input  logic signed [COORD_W-1:0] in_world_z,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] out_screen_x,
  output logic signed [COORD_W-1:0] out_screen_y,
  output logic                      out_visible,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata
);

  logic [CFG_W-1:0] r0ab_r, r0cd_r, r1ab_r, r1cd_r, r3ab_r, r3cd_r;
  logic [SCR_W-1:0] width_r, height_r;

  // Config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r0ab_r   <= '0;
      r0cd_r   <= '0;
      r1ab_r   <= '0;
      r1cd_r   <= '0;
      r3ab_r   <= '0;
      r3cd_r   <= '0;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW0_AB: r0ab_r   <= cfg_wdata;
        REG_ROW0_CD: r0cd_r   <= cfg_wdata;
        REG_ROW1_AB: r1ab_r   <= cfg_wdata;
        REG_ROW1_CD: r1cd_r   <= cfg_wdata;
        REG_ROW3_AB: r3ab_r   <= cfg_wdata;
        REG_ROW3_CD: r3cd_r   <= cfg_wdata;
        REG_WIDTH:   width_r  <= cfg_wdata[SCR_W-1:0];
        REG_HEIGHT:  height_r <= cfg_wdata[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Clip coordinates, two stages
  logic signed [COORD_W-1:0] cx, cy, cw;
  logic vld1_r, vld2_r, vld3_r;

  w2s_dot u_dot_x (.clk, .coef_ab(r0ab_r), .coef_cd(r0cd_r),
    .x(in_world_x), .y(in_world_y), .z(in_world_z), .clip_r(cx));
  w2s_dot u_dot_y (.clk, .coef_ab(r1ab_r), .coef_cd(r1cd_r),
    .x(in_world_x), .y(in_world_y), .z(in_world_z), .clip_r(cy));
  w2s_dot u_dot_w (.clk, .coef_ab(r3ab_r), .coef_cd(r3cd_r),
    .x(in_world_x), .y(in_world_y), .z(in_world_z), .clip_r(cw));

  // Prepare stage: visibility, magnitudes, hidden-point scaling
  side_t                     side3_r;
  logic [DIV_W-1:0]          numx3_r, numy3_r;
  logic [DEN_W-1:0]          den3_r;
  logic [COORD_W-1:0]        ax, ay;
  logic signed [HID_W-1:0]   hx, hy;

  assign ax = cx[COORD_W-1] ? ~cx + 1'b1 : cx;
  assign ay = cy[COORD_W-1] ? ~cy + 1'b1 : cy;
  assign hx = HID_W'(cx) * HID_W'(HID_SCALE);
  assign hy = HID_W'(cy) * HID_W'(HID_SCALE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= accept;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    side3_r.vis   <= cw >= COORD_W'(THRESH);
    side3_r.neg_x <= cx[COORD_W-1];
    side3_r.neg_y <= cy[COORD_W-1];
    side3_r.hid_x <= sat32(64'(hx));
    side3_r.hid_y <= sat32(64'(hy));
    numx3_r       <= {ax, FRAC_BITS'(0)};
    numy3_r       <= {ay, FRAC_BITS'(0)};
    den3_r        <= cw[DEN_W-1:0];
  end

  // Divide both clip coordinates by w
  logic             dvld;
  side_t            dside;
  logic [DIV_W-1:0] qx, qy;

  w2s_div u_div (.clk, .rst_n, .in_vld(vld3_r), .in_side(side3_r),
    .num_x(numx3_r), .num_y(numy3_r), .den(den3_r),
    .out_vld(dvld), .out_side(dside), .quo_x(qx), .quo_y(qy));

  // Viewport stage 1: clamp and sign the normalized coordinates
  logic                      vld4_r, vld5_r;
  side_t                     side4_r, side5_r;
  logic signed [NDC_W-1:0]   ndcx_r, ndcy_r;
  logic [NDC_MAG_W-1:0]      mx, my;

  assign mx = (qx > DIV_W'(NDC_LIM)) ? NDC_LIM : qx[NDC_MAG_W-1:0];
  assign my = (qy > DIV_W'(NDC_LIM)) ? NDC_LIM : qy[NDC_MAG_W-1:0];

  always_ff @(posedge clk) begin
    side4_r <= dside;
    ndcx_r  <= dside.neg_x ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
    ndcy_r  <= dside.neg_y ? -$signed({1'b0, my}) : $signed({1'b0, my});
  end

  // Viewport stage 2: scale by the viewport size
  logic signed [VP_PROD_W-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    side5_r <= side4_r;
    px_r    <= VP_PROD_W'(ndcx_r) * VP_PROD_W'($signed({1'b0, width_r}));
    py_r    <= VP_PROD_W'(ndcy_r) * VP_PROD_W'($signed({1'b0, height_r}));
  end

  // Viewport stage 3: center offset, saturate, select hidden path
  logic signed [VP_SUM_W-1:0] sx, sy;

  assign sx = (VP_SUM_W'($signed({1'b0, width_r})) <<< (FRAC_BITS - 1))
            + VP_SUM_W'(px_r >>> 1);
  assign sy = (VP_SUM_W'($signed({1'b0, height_r})) <<< (FRAC_BITS - 1))
            - VP_SUM_W'(py_r >>> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r    <= 1'b0;
      vld5_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld4_r    <= dvld;
      vld5_r    <= vld4_r;
      out_valid <= vld5_r;
    end
  end

  always_ff @(posedge clk) begin
    out_screen_x <= side5_r.vis ? sat32(64'(sx)) : side5_r.hid_x;
    out_screen_y <= side5_r.vis ? sat32(64'(sy)) : side5_r.hid_y;
    out_visible  <= side5_r.vis && vld5_r;
  end

  // A result beat only appears for a matching earlier start beat
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result beat without matching start beat");

  // Divider output lines up with the prepare stage valid
  a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
    dvld |-> $past(vld3_r, DIV_W))
    else $error("divider valid out of step");

  // Visible flag only rides on a result beat
  a_vis_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_visible |-> out_valid)
    else $error("visible flag without result beat");

endmodule

FILE: tb/w2s_projection_checker.sv
// Checker for the world-to-screen projection unit: watches the config port and
// both channels, predicts each result and compares it field by field.
// Depends on w2s_pkg.
`timescale 1ns / 1ps

module w2s_projection_checker import w2s_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic signed [COORD_W-1:0] in_world_x,
  input  logic signed [COORD_W-1:0] in_world_y,
  input  logic signed [COORD_W-1:0] in_world_z,
  input  logic                      out_valid,
  input  logic signed [COORD_W-1:0] out_screen_x,
  input  logic signed [COORD_W-1:0] out_screen_y,
  input  logic                      out_visible,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata,
  output int                        error_count,
  output int                        points_in_flight,
  output int                        visible_count,
  output int                        hidden_count
);

  typedef struct {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic                      vis;
  } screen_point_t;

  logic [CFG_W-1:0] matrix_regs [0:5];
  logic [SCR_W-1:0] view_w;
  logic [SCR_W-1:0] view_h;
  screen_point_t    expected_points [$];

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // One matrix row times (x, y, z, 1), each product floored to the fraction
  function automatic longint row_times_point(logic [CFG_W-1:0] ab, logic [CFG_W-1:0] cd,
                                             longint px, longint py, longint pz);
    longint c0, c1, c2, c3, acc;
    c0 = longint'(signed'(ab[31:0]));
    c1 = longint'(signed'(ab[63:32]));
    c2 = longint'(signed'(cd[31:0]));
    c3 = longint'(signed'(cd[63:32]));
    acc = ((c0 * px) >>> FRAC_BITS) + ((c1 * py) >>> FRAC_BITS)
        + ((c2 * pz) >>> FRAC_BITS) + c3;
    return clip32(acc);
  endfunction

  function automatic longint clamp_ndc(longint v);
    longint lim;
    lim = longint'(1) <<< 39;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic screen_point_t project_point(longint px, longint py, longint pz);
    screen_point_t r;
    longint cx, cy, cw, one, wd, ht, nx, ny;
    cx  = row_times_point(matrix_regs[0], matrix_regs[1], px, py, pz);
    cy  = row_times_point(matrix_regs[2], matrix_regs[3], px, py, pz);
    cw  = row_times_point(matrix_regs[4], matrix_regs[5], px, py, pz);
    one = longint'(1) <<< FRAC_BITS;
    wd  = longint'(view_w);
    ht  = longint'(view_h);
    if (cw < longint'(THRESH)) begin
      r.sx  = COORD_W'(clip32(cx * HID_SCALE));
      r.sy  = COORD_W'(clip32(cy * HID_SCALE));
      r.vis = 1'b0;
    end else begin
      nx    = clamp_ndc((cx * one) / cw);
      ny    = clamp_ndc((cy * one) / cw);
      r.sx  = COORD_W'(clip32(wd * (one / 2) + ((nx * wd) >>> 1)));
      r.sy  = COORD_W'(clip32(ht * (one / 2) - ((ny * ht) >>> 1)));
      r.vis = 1'b1;
    end
    return r;
  endfunction

  // Track config, predict on each accepted beat, compare each result beat
  always @(posedge clk) begin
    screen_point_t want;
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) matrix_regs[i] <= '0;
      view_w <= WIDTH_RST;
      view_h <= HEIGHT_RST;
      expected_points.delete();
      points_in_flight <= 0;
      error_count      <= 0;
      visible_count    <= 0;
      hidden_count     <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  view_w <= cfg_wdata[SCR_W-1:0];
          REG_HEIGHT: view_h <= cfg_wdata[SCR_W-1:0];
          default:    matrix_regs[cfg_index] <= cfg_wdata;
        endcase
      end
      if (start && !busy)
        expected_points.push_back(project_point(longint'(in_world_x),
                                                longint'(in_world_y),
                                                longint'(in_world_z)));
      if (out_valid) begin
        if (expected_points.size() == 0) begin
          error_count <= error_count + 1;
          if (error_count < 10)
            $display("%0t: result beat with nothing expected: x=%0d y=%0d vis=%0b",
                     $realtime, out_screen_x, out_screen_y, out_visible);
        end else begin
          want = expected_points.pop_front();
          if (out_visible) visible_count <= visible_count + 1;
          else hidden_count <= hidden_count + 1;
          if (want.sx !== out_screen_x || want.sy !== out_screen_y ||
              want.vis !== out_visible) begin
            error_count <= error_count + 1;
            if (error_count < 10)
              $display("%0t: mismatch: expected x=%0d y=%0d vis=%0b, got x=%0d y=%0d vis=%0b",
                       $realtime, want.sx, want.sy, want.vis,
                       out_screen_x, out_screen_y, out_visible);
          end
        end
      end
      points_in_flight <= expected_points.size();
    end
  end

endmodule

FILE: tb/world_to_screen_projection_unit_tb.sv
// Testbench top for the world-to-screen projection unit: clock, reset, config
// phases and point stimulus. Depends on w2s_pkg, the unit and w2s_projection_checker.
`timescale 1ns / 1ps

module world_to_screen_projection_unit_tb;
  import w2s_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_PHASES = 8;
  localparam int POINTS_PER_PHASE = 117;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [COORD_W-1:0] in_world_x = '0;
  logic signed [COORD_W-1:0] in_world_y = '0;
  logic signed [COORD_W-1:0] in_world_z = '0;
  logic                      out_valid;
  logic signed [COORD_W-1:0] out_screen_x;
  logic signed [COORD_W-1:0] out_screen_y;
  logic                      out_visible;
  logic                      cfg_we = 1'b0;
  logic [2:0]                cfg_index = '0;
  logic [CFG_W-1:0]          cfg_wdata = '0;

  int error_count, points_in_flight, visible_count, hidden_count;
  int points_sent = 0;
  int idle_cycles = 0;
  bit no_gaps = 0;

  always #5 clk = ~clk;

  world_to_screen_projection_unit DUT (.*);

  w2s_projection_checker checker_i (.*);

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic int gap_length();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one beat, holding it until taken; called and returns at a falling edge
  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    int gap;
    bit took;
    gap = gap_length();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      = 1'b1;
    in_world_x = px;
    in_world_y = py;
    in_world_z = pz;
    do begin
      took = !busy;
      @(negedge clk);
    end while (!took);
    points_sent++;
  endtask

  task automatic drain();
    start = 1'b0;
    while (points_in_flight != 0) @(negedge clk);
  endtask

  // Mostly small Q16.16 values, sometimes zero or anything at all
  function automatic logic [31:0] rand_coef();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom();
    if (r == 1) return '0;
    return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
  endfunction

  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return $urandom();
    if (r == 2) return 32'h7fff_ffff;
    if (r == 3) return 32'h8000_0000;
    if (r == 4) return '0;
    return 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
  endfunction

  // Random matrix: w row biased positive so most points land on screen
  task automatic load_random_setup(int phase);
    logic [31:0] w_bias;
    bit wild;
    logic [SCR_W-1:0] wd, ht;
    wild = ($urandom_range(0, 3) == 0);
    write_reg(REG_ROW0_AB, {rand_coef(), rand_coef()});
    write_reg(REG_ROW0_CD, {rand_coef(), rand_coef()});
    write_reg(REG_ROW1_AB, {rand_coef(), rand_coef()});
    write_reg(REG_ROW1_CD, {rand_coef(), rand_coef()});
    w_bias = 32'($urandom_range(1 << 16, 1 << 22));
    if (wild) begin
      write_reg(REG_ROW3_AB, {rand_coef(), rand_coef()});
      write_reg(REG_ROW3_CD, {w_bias, rand_coef()});
    end else begin
      write_reg(REG_ROW3_AB, {32'($signed($urandom_range(0, 8192)) - 4096),
                              32'($signed($urandom_range(0, 8192)) - 4096)});
      write_reg(REG_ROW3_CD, {w_bias, 32'($signed($urandom_range(0, 8192)) - 4096)});
    end
    case (phase)
      0:       begin wd = 14'd16383; ht = 14'd16383; end
      1:       begin wd = 14'd1;     ht = 14'd1;     end
      2:       begin wd = 14'd0;     ht = 14'd720;   end
      3:       begin wd = 14'd640;   ht = 14'd0;     end
      default: begin wd = 14'($urandom()); ht = 14'($urandom()); end
    endcase
    // Upper bits are junk the block must drop
    write_reg(REG_WIDTH,  {$urandom(), 18'($urandom()), wd});
    write_reg(REG_HEIGHT, {$urandom(), 18'($urandom()), ht});
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset setup: zero matrix, every point hidden at the origin
    send_point(32'h0001_0000, 32'hffff_0000, 32'h0002_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    drain();

    // Identity view: w equals z, so the threshold is easy to straddle
    write_reg(REG_ROW0_AB, {32'h0, 32'h0001_0000});
    write_reg(REG_ROW0_CD, '0);
    write_reg(REG_ROW1_AB, {32'h0001_0000, 32'h0});
    write_reg(REG_ROW1_CD, '0);
    write_reg(REG_ROW3_AB, '0);
    write_reg(REG_ROW3_CD, {32'h0, 32'h0001_0000});
    write_reg(REG_WIDTH,  64'(16383));
    write_reg(REG_HEIGHT, 64'(1));
    send_point(32'h0000_8000, 32'hffff_8000, 32'h0001_0000);
    send_point(32'h0001_0000, 32'h0001_0000, 32'(THRESH));
    send_point(32'h0001_0000, 32'hffff_0000, 32'(THRESH - 1));
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0);
    send_point(32'h0001_0000, 32'h0001_0000, 32'hffff_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'(THRESH));
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
    send_point(32'hffff_ffff, 32'h0000_0001, 32'h0001_0000);
    send_point(32'h0, 32'h0, 32'h7fff_ffff);
    drain();

    // Random phases, every other one back to back with no gaps
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      no_gaps = (p % 2 == 1);
      load_random_setup(p);
      for (int i = 0; i < POINTS_PER_PHASE; i++)
        send_point(rand_coord(), rand_coord(), rand_coord());
      drain();
    end

    repeat (LATENCY + 20) @(negedge clk);
    $display("Projected %0d points over %0d matrix/viewport setups", points_sent,
             RANDOM_PHASES + 2);
    $display("Results: %0d visible, %0d hidden, %0d mismatches", visible_count,
             hidden_count, error_count);
    if (error_count == 0 && points_in_flight == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: world_to_screen_projection_unit.f
src/w2s_pkg.sv
src/w2s_dot.sv
src/w2s_div.sv
src/world_to_screen_projection_unit.sv
tb/w2s_projection_checker.sv
tb/world_to_screen_projection_unit_tb.sv
